@@ src/hapa_pkg.sv @@
// hapa_pkg: shared constants, types and helper functions of the host address pool allocator
// no dependencies; imported by every module of the block
package hapa_pkg;

    // store geometry
    localparam int MAX_HOST_BITS = 8;
    localparam int HOST_W        = MAX_HOST_BITS;
    localparam int DEPTH         = 1 << HOST_W;
    localparam int ADDR_W        = 32;
    localparam int HB_W          = 4;
    localparam int FREE_W        = 8;

    localparam logic [HB_W-1:0] RESET_HOST_BITS = 4'd8;
    localparam logic [HB_W-1:0] MIN_HOST_BITS   = 4'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;

    // request kinds after classification
    localparam logic [1:0] CMD_LEASE   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_REJECT  = 2'd2;

    // register indexes
    localparam logic REG_NETWORK   = 1'b0;
    localparam logic REG_HOST_BITS = 1'b1;

    // request modes
    localparam logic MODE_LEASE = 1'b0;

    typedef struct packed {
        logic [1:0]        kind;
        logic [HOST_W-1:0] host;
        logic [ADDR_W-1:0] ip;
    } t_cmd;

    typedef struct packed {
        logic [FREE_W-1:0] free_count;
        logic [ADDR_W-1:0] granted;
        logic [1:0]        status;
    } t_result;

    // clamp a raw host_bits value into the supported range
    function automatic logic [HB_W-1:0] clamp_bits(input logic [HB_W-1:0] raw);
        logic [HB_W-1:0] b;
        b = raw;
        if (b < MIN_HOST_BITS) b = MIN_HOST_BITS;
        if (b > HB_W'(MAX_HOST_BITS)) b = HB_W'(MAX_HOST_BITS);
        return b;
    endfunction

    // highest host number for a clamped width
    function automatic logic [HOST_W-1:0] host_top(input logic [HB_W-1:0] eff);
        logic [HOST_W:0] t;
        t = ({{HOST_W{1'b0}}, 1'b1} << eff) - {{HOST_W{1'b0}}, 1'b1};
        return t[HOST_W-1:0];
    endfunction

    // network number, broadcast and the one below it are never handed out
    function automatic logic is_reserved(input logic [HOST_W-1:0] h,
                                         input logic [HOST_W-1:0] top);
        return (h == '0) || (h == top) || (h == top - {{(HOST_W-1){1'b0}}, 1'b1});
    endfunction

endpackage

@@ src/hapa_front.sv @@
// hapa_front: accepts request beats, classifies them and queues them for the back end
// depends on hapa_pkg
module hapa_front
    import hapa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_vld,
    output logic              o_s_rdy,
    input  logic              i_mode,
    input  logic [ADDR_W-1:0] i_ip,
    input  logic [ADDR_W-1:0] i_net,
    input  logic [HB_W-1:0]   i_eff_bits,
    output logic              o_cmd_vld,
    output t_cmd              o_cmd,
    input  logic              i_cmd_pop
);

    localparam int Q_DEPTH = 2;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    logic [HOST_W-1:0] top;
    logic [ADDR_W-1:0] net_mask;
    logic [HOST_W-1:0] host;
    logic              mismatch;
    t_cmd              cmd_in;
    logic              push;

    t_cmd              r_q [Q_DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [CNT_W-1:0]  r_cnt;

    // classify the incoming request
    always_comb begin
        top      = host_top(i_eff_bits);
        net_mask = ~{{(ADDR_W-HOST_W){1'b0}}, top};
        host     = i_ip[HOST_W-1:0] & top;
        mismatch = ((i_ip ^ i_net) & net_mask) != '0;
        cmd_in.ip   = i_ip;
        cmd_in.host = host;
        if (i_mode == MODE_LEASE) begin
            cmd_in.kind = mismatch ? CMD_REJECT : CMD_LEASE;
        end else begin
            cmd_in.kind = is_reserved(host, top) ? CMD_REJECT : CMD_RELEASE;
        end
    end

    assign o_s_rdy   = r_cnt != CNT_W'(Q_DEPTH);
    assign push      = i_s_vld && o_s_rdy;
    assign o_cmd_vld = r_cnt != '0;
    assign o_cmd     = r_q[r_rp];

    // queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_cmd_pop) r_rp <= r_rp + 1'b1;
            case ({push, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ src/hapa_back.sv @@
// hapa_back: carries out queued requests against the used-bit store and the free counter
// depends on hapa_pkg
module hapa_back
    import hapa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_vld,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    input  logic [HB_W-1:0]   i_eff_bits,
    input  logic              i_clr,
    input  logic [HB_W-1:0]   i_clr_bits,
    output logic              o_m_vld,
    input  logic              i_m_rdy,
    output t_result           o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_REL  = 2'd2;

    localparam logic [HOST_W-1:0] ONE = {{(HOST_W-1){1'b0}}, 1'b1};
    localparam logic [HOST_W-1:0] TWO = {{(HOST_W-2){1'b0}}, 2'b10};

    logic [1:0]        r_state, n_state;
    logic [HOST_W-1:0] r_free, n_free;
    logic              r_out_vld, n_out_vld;
    t_result           r_out, n_out;
    logic [ADDR_W-1:0] r_ip, n_ip;

    logic              mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic              r_rdata;
    logic              r_rvalid;
    logic [HOST_W-1:0] r_chk_addr;

    logic [HOST_W-1:0] top;
    logic [HOST_W-1:0] nxt;
    logic              chk_used;
    logic [HOST_W-1:0] rd_addr;
    logic              wr_en;
    logic              wr_bit;
    logic [ADDR_W-1:0] net_mask;

    // probe of the address whose used bit has just been read
    always_comb begin
        top      = host_top(i_eff_bits);
        net_mask = ~{{(ADDR_W-HOST_W){1'b0}}, top};
        chk_used = is_reserved(r_chk_addr, top) || (r_rvalid && r_rdata);
        nxt      = ((r_chk_addr == top) || (r_chk_addr == top - ONE)) ? '0 : r_chk_addr + ONE;
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_free    = r_free;
        n_out_vld = r_out_vld && !i_m_rdy;
        n_out     = r_out;
        n_ip      = r_ip;
        o_cmd_pop = 1'b0;
        rd_addr   = nxt;
        wr_en     = 1'b0;
        wr_bit    = 1'b0;
        case (r_state)
            S_IDLE: begin
                rd_addr = i_cmd.host;
                if (i_cmd_vld && !r_out_vld) begin
                    o_cmd_pop = 1'b1;
                    n_ip      = i_cmd.ip;
                    n_out.granted    = '0;
                    n_out.free_count = FREE_W'(r_free);
                    case (i_cmd.kind)
                        CMD_LEASE: begin
                            if (r_free == '0) begin
                                n_out.status = ST_EXHAUSTED;
                                n_out_vld    = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_RELEASE: begin
                            n_state = S_REL;
                        end
                        default: begin
                            n_out.status = ST_INVALID;
                            n_out_vld    = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!chk_used) begin
                    wr_en  = 1'b1;
                    wr_bit = 1'b1;
                    n_free = r_free - ONE;
                    n_out.status     = ST_OK;
                    n_out.granted    = (r_ip & net_mask) | {{(ADDR_W-HOST_W){1'b0}}, r_chk_addr};
                    n_out.free_count = FREE_W'(r_free - ONE);
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_REL: begin
                n_out.granted = '0;
                if (chk_used) begin
                    wr_en  = 1'b1;
                    wr_bit = 1'b0;
                    n_free = r_free + ONE;
                    n_out.status     = ST_OK;
                    n_out.free_count = FREE_W'(r_free + ONE);
                end else begin
                    n_out.status     = ST_INVALID;
                    n_out.free_count = FREE_W'(r_free);
                end
                n_out_vld = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // used-bit store, one read and one write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_chk_addr] <= wr_bit;
        end
        r_rdata    <= mem[rd_addr];
        r_chk_addr <= rd_addr;
    end

    // per-entry written marks, cleared at once by reset or a host_bits write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (wr_en) r_valid[r_chk_addr] <= 1'b1;
            r_rvalid <= r_valid[rd_addr];
        end
    end

    // control state and free counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_free    <= host_top(RESET_HOST_BITS) - TWO;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_free    <= i_clr ? host_top(i_clr_bits) - TWO : n_free;
        end
    end

    // result and request payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_ip  <= n_ip;
    end

    assign o_m_vld = r_out_vld;
    assign o_res   = r_out;

endmodule

@@ src/host_address_pool_allocator_top.sv @@
// host_address_pool_allocator_top: configuration registers and the front and back ends
// depends on hapa_pkg, hapa_front and hapa_back
//
// Address pool for one subnet. Each request beat carries a mode in tuser (lease or
// release) and an address in tdata; each yields exactly one result beat with a status
// in tuser and the granted address and free count in tdata. A lease with a matching
// network part takes the requested host number, or the next free one scanning upward
// and wrapping past the top two numbers to 0. The scan reads one used bit per cycle
// through the store's single read port. Release requests check the used bit in a
// release state; rejected and exhausted requests get their result straight from idle.
// Up to two requests queue ahead of the scan, so the input side keeps accepting while
// a result waits, until the queue is full. Writing host_bits clears the store at once
// through its per-entry written marks; there is no clearing pass after reset.
module host_address_pool_allocator_top
    import hapa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] ip_address
    input  logic [0:0]  s_axis_tuser,   // [0] mode
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] granted_address, [39:32] free_count
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [ADDR_W-1:0] r_net;
    logic [HB_W-1:0]   r_hb;
    logic [HB_W-1:0]   eff_bits;
    logic              cfg_wr;
    logic              clr;
    logic              cmd_vld;
    logic              cmd_pop;
    t_cmd              cmd;
    t_result           res;

    // register file
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign clr      = cfg_wr && (paddr[2] == REG_HOST_BITS);
    assign eff_bits = clamp_bits(r_hb);
    assign prdata   = (paddr[2] == REG_HOST_BITS) ? {{(32-HB_W){1'b0}}, r_hb} : r_net;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_net <= '0;
            r_hb  <= RESET_HOST_BITS;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_NETWORK) r_net <= pwdata;
            else                         r_hb  <= pwdata[HB_W-1:0];
        end
    end

    // request classification and queue
    hapa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_vld    (s_axis_tvalid),
        .o_s_rdy    (s_axis_tready),
        .i_mode     (s_axis_tuser[0]),
        .i_ip       (s_axis_tdata),
        .i_net      (r_net),
        .i_eff_bits (eff_bits),
        .o_cmd_vld  (cmd_vld),
        .o_cmd      (cmd),
        .i_cmd_pop  (cmd_pop)
    );

    // store access and result
    hapa_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_vld  (cmd_vld),
        .i_cmd      (cmd),
        .o_cmd_pop  (cmd_pop),
        .i_eff_bits (eff_bits),
        .i_clr      (clr),
        .i_clr_bits (clamp_bits(pwdata[HB_W-1:0])),
        .o_m_vld    (m_axis_tvalid),
        .i_m_rdy    (m_axis_tready),
        .o_res      (res)
    );

    assign m_axis_tdata = {res.free_count, res.granted};
    assign m_axis_tuser = res.status;

endmodule

@@ src/hapa_checker.sv @@
// hapa_checker: port-level checks on the result stream of the address pool allocator
// depends on hapa_pkg; bound to host_address_pool_allocator_top
module hapa_checker
    import hapa_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result beat holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // only a successful lease carries an address
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata[31:0] == '0)
        else $error("address on a failed request");

    // a granted address never names the subnet's network number
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_OK) && (m_axis_tdata[31:0] != '0)
            |-> m_axis_tdata[7:0] != 8'd0)
        else $error("reserved host number granted");

    // free count stays within the usable host numbers
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:32] <= 8'd253)
        else $error("free count out of range");

    // an exhausted result reports an empty pool
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_EXHAUSTED) |-> m_axis_tdata[39:32] == 8'd0)
        else $error("exhausted with free hosts left");

endmodule

bind host_address_pool_allocator_top hapa_checker u_hapa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ verif/host_address_pool_allocator_checker.sv @@
// host_address_pool_allocator_checker: watches the request, result and register channels
// of the address pool, predicts each result beat and compares it; depends on hapa_pkg
`timescale 1ns / 100ps

module host_address_pool_allocator_checker
    import hapa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [31:0] i_req_data,    // [31:0] ip_address
    input  logic [0:0]  i_req_user,    // [0] mode
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [39:0] i_res_data,    // [31:0] granted_address, [39:32] free_count
    input  logic [1:0]  i_res_user,    // [1:0] status
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_mismatches,
    output int          o_outstanding
);

    // shadow of the pool and its registers
    logic [DEPTH-1:0]  lease_map;
    logic [FREE_W-1:0] free_hosts;
    logic [ADDR_W-1:0] subnet;
    logic [HB_W-1:0]   host_bits_raw;

    t_result pending_results[$];

    // host bits after clamping into 2..8
    function automatic logic [HB_W-1:0] width_now();
        logic [HB_W-1:0] w;
        w = host_bits_raw;
        if (w < 4'd2) w = 4'd2;
        if (w > 4'(MAX_HOST_BITS)) w = 4'(MAX_HOST_BITS);
        return w;
    endfunction

    function automatic logic [HOST_W-1:0] top_now();
        logic [HOST_W:0] t;
        t = ((HOST_W + 1)'(1) << width_now()) - (HOST_W + 1)'(1);
        return t[HOST_W-1:0];
    endfunction

    // empty pool with network number, broadcast and the one below it held back
    task automatic clear_pool();
        logic [HOST_W-1:0] top;
        top = top_now();
        lease_map = '0;
        lease_map[0] = 1'b1;
        lease_map[top] = 1'b1;
        lease_map[top - 1'b1] = 1'b1;
        free_hosts = FREE_W'(top - 2'd2);
    endtask

    // lease or release against the shadow pool, giving the result it should produce
    task automatic predict_grant(input logic mode, input logic [ADDR_W-1:0] ip,
                                 output t_result res);
        logic [HB_W-1:0]   w;
        logic [HOST_W-1:0] top;
        logic [HOST_W-1:0] host;
        logic [HOST_W-1:0] probe;
        logic              found;
        int                n;
        w = width_now();
        top = top_now();
        host = ip[HOST_W-1:0] & top;
        res.status = ST_OK;
        res.granted = '0;
        if (mode == MODE_LEASE) begin
            if ((ip >> w) != (subnet >> w)) begin
                res.status = ST_INVALID;
            end else if (free_hosts == '0) begin
                res.status = ST_EXHAUSTED;
            end else begin
                // walk upward from the requested number, wrapping past the top two
                probe = host;
                found = 1'b0;
                n = 0;
                while (!found && n <= int'(top)) begin
                    if (!lease_map[probe]) begin
                        found = 1'b1;
                    end else begin
                        probe = (probe == top || probe == top - 1'b1) ? '0 : probe + 1'b1;
                        n++;
                    end
                end
                if (found) begin
                    lease_map[probe] = 1'b1;
                    free_hosts = free_hosts - 1'b1;
                    res.granted = (ip & ~ADDR_W'(top)) | ADDR_W'(probe);
                end else begin
                    res.status = ST_EXHAUSTED;
                end
            end
        end else begin
            // release looks at the host part only
            if (host == '0 || host == top || host == top - 1'b1 || !lease_map[host]) begin
                res.status = ST_INVALID;
            end else begin
                lease_map[host] = 1'b0;
                free_hosts = free_hosts + 1'b1;
            end
        end
        res.free_count = free_hosts;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            subnet = '0;
            host_bits_raw = RESET_HOST_BITS;
            clear_pool();
            pending_results.delete();
            o_mismatches = 0;
        end else begin
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_NETWORK) begin
                    subnet = i_pwdata;
                end else begin
                    host_bits_raw = i_pwdata[HB_W-1:0];
                    clear_pool();
                end
            end
            // result beats against the oldest prediction
            if (i_res_valid && i_res_ready) begin
                got.status = i_res_user;
                got.granted = i_res_data[31:0];
                got.free_count = i_res_data[39:32];
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected: status %0d granted %h free %0d",
                           got.status, got.granted, got.free_count);
                    o_mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        o_mismatches++;
                    end
                    if (got.granted !== want.granted) begin
                        $error("granted_address: expected %h, actual %h",
                               want.granted, got.granted);
                        o_mismatches++;
                    end
                    if (got.free_count !== want.free_count) begin
                        $error("free_count: expected %0d, actual %0d",
                               want.free_count, got.free_count);
                        o_mismatches++;
                    end
                end
            end
            // request beats
            if (i_req_valid && i_req_ready) begin
                predict_grant(i_req_user[0], i_req_data, want);
                pending_results.push_back(want);
            end
        end
        o_outstanding = pending_results.size();
    end

endmodule

@@ verif/host_address_pool_allocator_top_tb.sv @@
// host_address_pool_allocator_top_tb: clock, reset, request and register stimulus, result
// sink and verdict for the address pool; depends on hapa_pkg, the block and its checker
`timescale 1ns / 100ps

module host_address_pool_allocator_top_tb;
    import hapa_pkg::*;

    localparam logic MODE_RELEASE = !MODE_LEASE;
    localparam int   PHASES       = 14;
    localparam int   PHASE_ITEMS  = 95;
    localparam int   LONG_HOLD    = 300;
    localparam int   DRAIN_CYCLES = 300;
    localparam int   STALL_LIMIT  = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;     // [31:0] ip_address
    logic [0:0]  s_axis_tuser;     // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;     // [31:0] granted_address, [39:32] free_count
    logic [1:0]  m_axis_tuser;     // [1:0] status
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int outstanding;
    int results_seen;
    int quiet_cycles;
    bit calm;

    host_address_pool_allocator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    host_address_pool_allocator_checker pool_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_data    (s_axis_tdata),
        .i_req_user    (s_axis_tuser),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_res_user    (m_axis_tuser),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one request beat, held until accepted
    task automatic send_request(input logic mode, input logic [31:0] ip);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ip;
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // setup then access cycle
    task automatic reg_write(input logic idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // result beats seen, used to time the long hold-off
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) results_seen <= results_seen + 1;
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("host_address_pool_allocator_top regression: fail");
            $finish;
        end
    end

    // result sink with random stalls and a long hold-off now and then
    initial begin : result_sink
        int stall_left;
        int next_hold;
        m_axis_tready = 1'b0;
        stall_left = 0;
        next_hold = 150;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (results_seen >= next_hold) begin
                // sender keeps offering so the block backs up
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                next_hold = next_hold + 550;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = gap_len();
            end
        end
    end

    initial begin : stimulus
        int          phase;
        int          k;
        int          r;
        int          width;
        logic [3:0]  raw_bits;
        logic [31:0] net;
        logic [31:0] mask;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        calm          = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: subnet 0, eight host bits
        send_request(MODE_LEASE, 32'h0000_0000);     // reserved number zero, next is 1
        send_request(MODE_LEASE, 32'h0000_00FE);     // reserved, wraps to 0 then scans
        send_request(MODE_LEASE, 32'h0000_00FF);     // broadcast, wraps
        send_request(MODE_LEASE, 32'h0000_0080);     // free, granted as asked
        send_request(MODE_LEASE, 32'hFFFF_FFFF);     // network mismatch
        send_request(MODE_LEASE, 32'h0000_0100);     // lowest network bit differs
        send_request(MODE_RELEASE, 32'h0000_0080);
        send_request(MODE_RELEASE, 32'h0000_0080);   // not leased any more
        send_request(MODE_RELEASE, 32'h0000_0000);   // reserved
        send_request(MODE_RELEASE, 32'h0000_00FF);   // reserved
        send_request(MODE_RELEASE, 32'hFFFF_FFFE);   // reserved
        send_request(MODE_RELEASE, 32'hABCD_EF01);   // network ignored on release

        // smallest subnet: one usable number
        settle();
        reg_write(REG_NETWORK, 32'hFFFF_FFFF);
        reg_write(REG_HOST_BITS, 32'd2);
        send_request(MODE_LEASE, 32'hFFFF_FFFC);
        send_request(MODE_LEASE, 32'hFFFF_FFFF);     // pool exhausted
        send_request(MODE_RELEASE, 32'h0000_0001);
        send_request(MODE_LEASE, 32'hFFFF_FFFE);     // reserved, wraps round to 1
        send_request(MODE_LEASE, 32'h7FFF_FFFD);     // top bit mismatch
        send_request(MODE_RELEASE, 32'h0000_0002);   // reserved

        // random phases over many subnet settings, mostly small pools
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: raw_bits = 4'd0;
                1: raw_bits = 4'd15;
                2: raw_bits = 4'd3;
                default: begin
                    r = $urandom_range(0, 9);
                    if (r < 5) raw_bits = 4'($urandom_range(2, 5));
                    else if (r < 8) raw_bits = 4'($urandom_range(6, 8));
                    else if ($urandom_range(0, 1)) raw_bits = 4'($urandom_range(0, 1));
                    else raw_bits = 4'($urandom_range(9, 15));
                end
            endcase
            if (phase == 0) net = 32'h0000_0000;
            else if (phase == 1) net = 32'hFFFF_FFFF;
            else net = $urandom;
            width = (raw_bits < 4'd2) ? 2 : (raw_bits > 4'd8) ? 8 : int'(raw_bits);
            mask = (32'd1 << width) - 32'd1;
            settle();
            calm = ($urandom_range(0, 3) == 0);
            reg_write(REG_NETWORK, net);
            reg_write(REG_HOST_BITS, ($urandom & 32'hFFFF_FFF0) | 32'(raw_bits));
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // new subnet mid-phase while the pool keeps its leases
                if (k == PHASE_ITEMS / 2 && $urandom_range(0, 1)) begin
                    settle();
                    net = $urandom;
                    reg_write(REG_NETWORK, net);
                end
                r = $urandom_range(0, 99);
                if (r < 55) send_request(MODE_LEASE, (net & ~mask) | ($urandom & mask));
                else if (r < 85) send_request(MODE_RELEASE, $urandom);
                else send_request(1'($urandom_range(0, 1)), $urandom);
            end
        end

        // drain
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("host_address_pool_allocator_top regression: pass");
        end else begin
            $display("host_address_pool_allocator_top regression: fail");
        end
        $finish;
    end

endmodule
